### hdl/stp_pkg.sv
package stp_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int OUT_VALUE_W = 64;
  localparam int MAX_CHARS   = 4096;
  localparam int POS_W       = $clog2(MAX_CHARS + 1);
  localparam int OFFSET_W    = 13;
  localparam int CH_W        = 8;
  localparam int BASE_W      = 6;
  localparam int DIGIT_W     = 6;
  localparam int PROD_W      = VALUE_BITS + BASE_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BASE_W-1:0]  BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0]  BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0]  BASE_OCT   = BASE_W'(8);
  localparam logic [BASE_W-1:0]  BASE_DEC   = BASE_W'(10);
  localparam logic [BASE_W-1:0]  BASE_HEX   = BASE_W'(16);
  localparam logic [BASE_W-1:0]  BASE_ONE   = BASE_W'(1);
  localparam logic [DIGIT_W-1:0] NO_DIGIT   = '1;

  localparam logic [VALUE_BITS-1:0] VMASK = '1;
  localparam logic [VALUE_BITS-1:0] VHALF = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_DIGITS,
    ST_OVERFLOW,
    ST_BAD_BASE
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMBER_BASE,
    REG_UNSIGNED_MODE
  } reg_index_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               space;
    logic               minus;
    logic               plus;
    logic               xchar;
    logic               last;
  } word_t;

  typedef struct packed {
    logic [BASE_W-1:0] number_base;
    logic              unsigned_mode;
  } cfg_t;

endpackage

### hdl/stp_if.sv
interface stp_in_if;
  import stp_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            string_end;

  modport source(output valid, ch, string_end, input ready);
  modport sink(input valid, ch, string_end, output ready);
endinterface

interface stp_out_if;
  import stp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OUT_VALUE_W-1:0] value;
  logic [OFFSET_W-1:0]    end_offset;
  logic [1:0]             status;

  modport source(output valid, value, end_offset, status, input ready);
  modport sink(input valid, value, end_offset, status, output ready);
endinterface

### hdl/stp_front.sv
module stp_front (
  stp_in_if.sink         chars,
  input  logic           q_ready,
  output logic           push,
  output stp_pkg::word_t word
);
  import stp_pkg::*;

  localparam logic [CH_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CH_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CH_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CH_W-1:0] CHAR_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CH_W-1:0] CHAR_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] CHAR_UPPER = 8'h37;
  localparam logic [CH_W-1:0] CHAR_LOWER = 8'h57;
  localparam logic [CH_W-1:0] CHAR_SP    = 8'h20;
  localparam logic [CH_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CHAR_UX    = 8'h58;
  localparam logic [CH_W-1:0] CHAR_LX    = 8'h78;

  logic [CH_W-1:0] ch;

  assign ch = chars.ch;
  assign chars.ready = q_ready;
  assign push = chars.valid & q_ready;

  always_comb begin
    word = '0;
    if (ch >= CHAR_0 && ch <= CHAR_9) begin
      word.digit = DIGIT_W'(ch - CHAR_0);
    end else if (ch >= CHAR_UA && ch <= CHAR_UZ) begin
      word.digit = DIGIT_W'(ch - CHAR_UPPER);
    end else if (ch >= CHAR_LA && ch <= CHAR_LZ) begin
      word.digit = DIGIT_W'(ch - CHAR_LOWER);
    end else begin
      word.digit = NO_DIGIT;
    end
    word.space = (ch == CHAR_SP) || (ch >= CHAR_TAB && ch <= CHAR_CR);
    word.minus = (ch == CHAR_MINUS);
    word.plus  = (ch == CHAR_PLUS);
    word.xchar = (ch == CHAR_UX) || (ch == CHAR_LX);
    word.last  = chars.string_end;
  end

endmodule

### hdl/stp_queue.sv
module stp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  stp_pkg::word_t wr_word,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output stp_pkg::word_t rd_word
);
  import stp_pkg::*;

  word_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign q_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign rd_word = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/stp_back.sv
module stp_back (
  input  logic           clk,
  input  logic           rst,
  input  stp_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  stp_pkg::word_t word,
  output logic           pop,
  stp_out_if.source      results
);
  import stp_pkg::*;

  phase_t                phase;
  logic [VALUE_BITS-1:0] acc;
  logic [BASE_W-1:0]     wb;
  logic                  neg;
  logic                  ovf;
  logic                  dig;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      stop_pos;

  phase_t                phase_next;
  logic [VALUE_BITS-1:0] acc_next;
  logic [BASE_W-1:0]     wb_next;
  logic                  neg_next;
  logic                  ovf_next;
  logic                  dig_next;
  logic [POS_W-1:0]      pos_next;
  logic [POS_W-1:0]      stop_pos_next;

  phase_t                phase_step;
  logic [VALUE_BITS-1:0] acc_step;
  logic [BASE_W-1:0]     wb_step;
  logic                  neg_step;
  logic                  ovf_step;
  logic                  dig_step;
  logic [POS_W-1:0]      pos_step;
  logic [POS_W-1:0]      stop_step;

  logic                  take;
  logic                  first;
  logic                  bad_base;
  logic                  consumed;
  logic                  use_digit;
  logic                  digit_ok;
  logic                  finish;
  logic                  restart;
  logic                  emit;
  phase_t                cur;
  logic [BASE_W-1:0]     wb_cur;
  logic [BASE_W-1:0]     b_sel;
  logic [POS_W-1:0]      pos_inc;
  logic [VALUE_BITS-1:0] maxv;
  logic [PROD_W-1:0]     prod;
  logic                  prod_over;

  logic                  res_valid;
  logic [VALUE_BITS-1:0] res_mag;
  logic                  res_neg;
  logic [POS_W-1:0]      res_offset;
  status_t               res_status;

  logic [VALUE_BITS-1:0] res_mag_next;
  logic                  res_neg_next;
  logic [POS_W-1:0]      res_offset_next;
  status_t               res_status_next;
  logic [VALUE_BITS-1:0] out_bits;

  assign take = q_valid && (!res_valid || results.ready);
  assign pop  = take;

  always_comb begin
    first    = (pos == '0) && (phase == PH_SPACE);
    wb_cur   = first ? cfg.number_base : wb;
    bad_base = (phase != PH_DONE) && first &&
               ((cfg.number_base == BASE_ONE) || (cfg.number_base > BASE_MAX));
    pos_inc  = (pos < POS_W'(MAX_CHARS)) ? pos + POS_W'(1) : pos;
    cur      = phase;
    consumed = 1'b0;
    if (phase == PH_SPACE) begin
      cur = PH_SIGN;
      if (word.space || word.minus || word.plus) begin
        consumed = 1'b1;
      end
    end
    use_digit = 1'b0;
    b_sel     = wb_cur;
    if (!consumed) begin
      case (cur)
        PH_SIGN: begin
          if (!(word.digit == '0 && (wb_cur == '0 || wb_cur == BASE_HEX))) begin
            use_digit = 1'b1;
            b_sel     = (wb_cur == '0) ? BASE_DEC : wb_cur;
          end
        end
        PH_ZERO: begin
          if (!word.xchar) begin
            use_digit = 1'b1;
            b_sel     = (wb_cur == '0) ? BASE_OCT : wb_cur;
          end
        end
        PH_XSEEN: begin
          use_digit = 1'b1;
          b_sel     = BASE_HEX;
        end
        default: use_digit = 1'b1;
      endcase
    end
    digit_ok = (word.digit < b_sel);
    finish   = (phase != PH_DONE) && !bad_base &&
               ((use_digit && !digit_ok) || word.last);
    restart  = word.last;
  end

  always_comb begin
    if (cfg.unsigned_mode) begin
      maxv = VMASK;
    end else begin
      maxv = neg ? VHALF : VHALF - VALUE_BITS'(1);
    end
  end

  assign prod      = PROD_W'(acc) * PROD_W'(b_sel) + PROD_W'(word.digit);
  assign prod_over = prod > PROD_W'(maxv);

  always_comb begin
    phase_step = phase;
    acc_step   = acc;
    wb_step    = wb;
    neg_step   = neg;
    ovf_step   = ovf;
    dig_step   = dig;
    pos_step   = pos;
    stop_step  = stop_pos;
    if (phase == PH_DONE) begin
      phase_step = PH_DONE;
    end else if (bad_base) begin
      phase_step = PH_DONE;
    end else begin
      wb_step  = wb_cur;
      pos_step = pos_inc;
      if (phase == PH_SPACE && !word.space) begin
        phase_step = PH_SIGN;
        if (word.minus || word.plus) begin
          neg_step = word.minus;
        end
      end
      if (!consumed) begin
        if (use_digit) begin
          wb_step = b_sel;
          if (digit_ok) begin
            dig_step   = 1'b1;
            ovf_step   = ovf || prod_over;
            if (!(ovf || prod_over)) begin
              acc_step = prod[VALUE_BITS-1:0];
            end
            stop_step  = pos_inc;
            phase_step = PH_DIGITS;
          end
        end else if (cur == PH_SIGN) begin
          dig_step   = 1'b1;
          stop_step  = pos_inc;
          phase_step = PH_ZERO;
        end else begin
          phase_step = PH_XSEEN;
        end
      end
      if (finish) begin
        phase_step = PH_DONE;
      end
    end
  end

  always_comb begin
    if (restart) begin
      phase_next    = PH_SPACE;
      acc_next      = '0;
      wb_next       = '0;
      neg_next      = 1'b0;
      ovf_next      = 1'b0;
      dig_next      = 1'b0;
      pos_next      = '0;
      stop_pos_next = '0;
    end else begin
      phase_next    = phase_step;
      acc_next      = acc_step;
      wb_next       = wb_step;
      neg_next      = neg_step;
      ovf_next      = ovf_step;
      dig_next      = dig_step;
      pos_next      = pos_step;
      stop_pos_next = stop_step;
    end
  end

  always_comb begin
    emit            = take && (bad_base || finish);
    res_mag_next    = '0;
    res_neg_next    = 1'b0;
    res_offset_next = '0;
    res_status_next = ST_OK;
    if (bad_base) begin
      res_status_next = ST_BAD_BASE;
    end else if (!dig_step) begin
      res_status_next = ST_NO_DIGITS;
    end else if (ovf_step) begin
      res_status_next = ST_OVERFLOW;
      res_mag_next    = maxv;
      res_offset_next = stop_step;
    end else begin
      res_mag_next    = acc_step;
      res_neg_next    = neg_step;
      res_offset_next = stop_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SPACE;
      acc      <= '0;
      wb       <= '0;
      neg      <= 1'b0;
      ovf      <= 1'b0;
      dig      <= 1'b0;
      pos      <= '0;
      stop_pos <= '0;
    end else if (take) begin
      phase    <= phase_next;
      acc      <= acc_next;
      wb       <= wb_next;
      neg      <= neg_next;
      ovf      <= ovf_next;
      dig      <= dig_next;
      pos      <= pos_next;
      stop_pos <= stop_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_mag    <= res_mag_next;
      res_neg    <= res_neg_next;
      res_offset <= res_offset_next;
      res_status <= res_status_next;
    end
  end

  assign out_bits           = res_neg ? ('0 - res_mag) : res_mag;
  assign results.valid      = res_valid;
  assign results.value      = OUT_VALUE_W'(out_bits);
  assign results.end_offset = OFFSET_W'(res_offset);
  assign results.status     = res_status;

  a_ovf_needs_digit: assert property (@(posedge clk) disable iff (rst)
    ovf |-> dig)
    else $error("overflow flagged without a digit");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_CHARS))
    else $error("character position past limit");

  a_stop_behind_pos: assert property (@(posedge clk) disable iff (rst)
    stop_pos <= pos)
    else $error("stop position ahead of character position");

  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    (emit && !word.last) |=> (phase == PH_DONE))
    else $error("parser not parked after early result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_status == ST_BAD_BASE || res_status == ST_NO_DIGITS))
      |-> (res_mag == '0 && res_offset == '0))
    else $error("empty result carries value or offset");

endmodule

### hdl/string_to_integer_parser.sv
// A result is registered at the output once the character ending the parse leaves the queue.
// Throughput: 1 character per cycle unless the queue is full; 64x6 multiply-add per digit.
// A 2-word queue separates character decode from the parser. A result waiting in the
// output register stalls the parser; the queue still takes up to two more characters.
// Reset (rst, synchronous): queue and parser cleared, number_base = 10, unsigned_mode = 0.
module string_to_integer_parser (
  input  logic                            clk,
  input  logic                            rst,
  stp_in_if.sink                          chars,
  stp_out_if.source                       results,
  input  logic                            cfg_we,
  input  logic [stp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import stp_pkg::*;

  cfg_t  cfg;
  word_t in_word;
  word_t q_word;
  logic  push;
  logic  q_ready;
  logic  q_valid;
  logic  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_base   <= BASE_RESET;
      cfg.unsigned_mode <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_NUMBER_BASE:   cfg.number_base   <= cfg_wdata[BASE_W-1:0];
        REG_UNSIGNED_MODE: cfg.unsigned_mode <= cfg_wdata[0];
        default:           cfg <= cfg;
      endcase
    end
  end

  stp_front u_front (
    .chars   (chars),
    .q_ready (q_ready),
    .push    (push),
    .word    (in_word)
  );

  stp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_word (in_word),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .rd_word (q_word)
  );

  stp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .word    (q_word),
    .pop     (pop),
    .results (results)
  );

endmodule
